// File: design/gmcp_pkg.sv
// Shared types and constants for the grid minimum-cost path block.
`timescale 1ns / 1ps
`default_nettype none

package gmcp_pkg;

  // Running path costs saturate to this signed width.
  localparam int COST_W = 24;
  localparam logic signed [COST_W-1:0] COST_MAX = {1'b0, {(COST_W-1){1'b1}}};
  localparam logic signed [COST_W-1:0] COST_MIN = {1'b1, {(COST_W-1){1'b0}}};

  // Configuration channel.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 8'd1;

  typedef logic signed [COST_W-1:0] cost_t;

  // Position of a cell at the grid edges.
  typedef struct packed {
    logic first_row;
    logic first_col;
  } gmcp_pos_t;

endpackage : gmcp_pkg

`default_nettype wire

// File: design/gmcp_if.sv
// Handshake channel interfaces: cell input, cost output, configuration write.
`timescale 1ns / 1ps
`default_nettype none

interface gmcp_cell_if #(
  parameter int CELL_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [CELL_BITS-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface : gmcp_cell_if

interface gmcp_cost_if
  import gmcp_pkg::*;
;
  logic  valid;
  logic  ready;
  cost_t path_cost;

  modport source (output valid, output path_cost, input ready);
  modport sink   (input valid, input path_cost, output ready);
endinterface : gmcp_cost_if

interface gmcp_cfg_if
  import gmcp_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : gmcp_cfg_if

`default_nettype wire

// File: design/gmcp_cost_calc.sv
// Cell cost: value plus the best neighbor cost, saturated to the cost width.
`timescale 1ns / 1ps
`default_nettype none

module gmcp_cost_calc
  import gmcp_pkg::*;
#(
  parameter int CELL_BITS = 16
) (
  input  var logic signed [CELL_BITS-1:0] cell_value_i,
  input  var gmcp_pos_t                   pos_i,
  input  var cost_t                       above_i,
  input  var cost_t                       diag_i,
  input  var cost_t                       left_i,
  output cost_t                           cost_o
);

  localparam int SUM_W = ((CELL_BITS > COST_W) ? CELL_BITS : COST_W) + 1;

  cost_t                   min_dl;
  cost_t                   best;
  logic signed [SUM_W-1:0] sum;

  always_comb begin
    min_dl = (diag_i < left_i) ? diag_i : left_i;
    if (pos_i.first_row && pos_i.first_col) begin
      best = '0;
    end else if (pos_i.first_row) begin
      best = left_i;
    end else if (pos_i.first_col) begin
      best = above_i;
    end else begin
      best = (above_i < min_dl) ? above_i : min_dl;
    end
    sum = SUM_W'(best) + SUM_W'(cell_value_i);
    if (sum > SUM_W'(COST_MAX)) begin
      cost_o = COST_MAX;
    end else if (sum < SUM_W'(COST_MIN)) begin
      cost_o = COST_MIN;
    end else begin
      cost_o = sum[COST_W-1:0];
    end
  end

endmodule : gmcp_cost_calc

`default_nettype wire

// File: design/grid_min_cost_path.sv
// Top level: streaming minimum-cost path over a raster-order signed grid.
//
//   port    | dir | payload                    | transaction
//   --------+-----+----------------------------+---------------------------------
//   cfg_i   | in  | index, data (8 bits)       | write grid_rows (0) / grid_cols (1)
//   cell_i  | in  | cell_value (CELL_BITS, s)  | one grid cell, raster order
//   cost_o  | out | path_cost (24 bits, s)     | one per grid, after the last cell
//
// Cycles: one cell per clock, except while a finishing cell waits on a held result.
// The row-cost memory is read at accept into a read register; stage 1 adds the cost
// and writes it back as it retires; the final cost then fills the output register.
// Reset: counters, neighbor costs and the output valid clear; grid size is 1x1.
// The row memory needs no clearing pass: each grid writes a row before reading it.
// Stalls: a held result only blocks the pipeline when the next grid finishes.
`timescale 1ns / 1ps
`default_nettype none

module grid_min_cost_path
  import gmcp_pkg::*;
#(
  parameter int MAX_COLS  = 128,
  parameter int MAX_ROWS  = 128,
  parameter int CELL_BITS = 16
) (
  input var logic clk_i,
  input var logic rst_ni,
  gmcp_cfg_if.sink                     cfg_i,
  gmcp_cell_if.sink                    cell_i,
  gmcp_cost_if.source                  cost_o
);

  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int DIMC_W = $clog2(MAX_COLS + 1);
  localparam int DIMR_W = $clog2(MAX_ROWS + 1);
  // Wide enough for both the 8-bit registers and the largest dimension.
  localparam int DIM_W  = (DIMC_W > DIMR_W) ?
                          ((DIMC_W > CFG_DATA_W) ? DIMC_W : CFG_DATA_W) :
                          ((DIMR_W > CFG_DATA_W) ? DIMR_W : CFG_DATA_W);

  // ---------------------------------------------------------------- config
  logic [CFG_DATA_W-1:0] grid_rows_q, grid_cols_q;
  logic                  cfg_acc;
  logic                  cfg_hit;

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid;
  // Writes to unknown indexes are dropped and do not restart the grid.
  assign cfg_hit     = cfg_acc &&
                       (cfg_i.index == REG_GRID_ROWS || cfg_i.index == REG_GRID_COLS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= CFG_DATA_W'(1);
      grid_cols_q <= CFG_DATA_W'(1);
    end else if (cfg_acc) begin
      unique case (cfg_i.index)
        REG_GRID_ROWS: grid_rows_q <= cfg_i.data;
        REG_GRID_COLS: grid_cols_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Effective size: zero acts as one, oversize clamps to the maximum.
  logic [DIM_W-1:0] rows_ext, cols_ext, rows_eff, cols_eff, rows_m1, cols_m1;
  logic [ROW_W-1:0] rows_last;
  logic [COL_W-1:0] cols_last;

  always_comb begin
    rows_ext = DIM_W'(grid_rows_q);
    cols_ext = DIM_W'(grid_cols_q);
    if (rows_ext == '0) begin
      rows_eff = DIM_W'(1);
    end else if (rows_ext > DIM_W'(MAX_ROWS)) begin
      rows_eff = DIM_W'(MAX_ROWS);
    end else begin
      rows_eff = rows_ext;
    end
    if (cols_ext == '0) begin
      cols_eff = DIM_W'(1);
    end else if (cols_ext > DIM_W'(MAX_COLS)) begin
      cols_eff = DIM_W'(MAX_COLS);
    end else begin
      cols_eff = cols_ext;
    end
    rows_m1   = rows_eff - DIM_W'(1);
    cols_m1   = cols_eff - DIM_W'(1);
    rows_last = rows_m1[ROW_W-1:0];
    cols_last = cols_m1[COL_W-1:0];
  end

  // ---------------------------------------------------------------- stage 0
  // Position of the next cell; the memory read for its column issues at accept.
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic             in_acc;
  logic             s1_valid_q, s1_last_q, fwd_q, s1_go;
  logic             col_end, row_end;

  assign in_acc  = cell_i.valid && cell_i.ready;
  assign col_end = (col_q == cols_last);
  assign row_end = (row_q == rows_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cfg_hit) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_acc) begin
      if (col_end) begin
        col_q <= '0;
        row_q <= row_end ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic signed [CELL_BITS-1:0] s1_value_q;
  logic [COL_W-1:0]            s1_col_q;
  gmcp_pos_t                   s1_pos_q;
  cost_t                       rd_data_q;
  cost_t                       left_q, diag_q;
  cost_t                       above, cost;
  cost_t                       row_costs_q [MAX_COLS];
  logic                        out_valid_q;
  cost_t                       out_cost_q;

  // A finishing cell waits only if the previous result is still held.
  assign s1_go       = s1_valid_q && (!s1_last_q || !out_valid_q || cost_o.ready);
  assign cell_i.ready = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
      fwd_q      <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
      s1_last_q  <= col_end && row_end;
      // Single-column grid: the cell in stage 1 writes the entry read now.
      fwd_q      <= s1_go && (s1_col_q == col_q);
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_value_q         <= cell_i.cell_value;
      s1_col_q           <= col_q;
      s1_pos_q.first_row <= (row_q == '0);
      s1_pos_q.first_col <= (col_q == '0);
    end
  end

  // Row-cost memory: one read at accept, one write when stage 1 retires.
  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      row_costs_q[s1_col_q] <= cost;
    end
    if (in_acc) begin
      rd_data_q <= row_costs_q[col_q];
    end
  end

  // Forwarded cost is the one just written, which is also the left neighbor.
  assign above = fwd_q ? left_q : rd_data_q;

  gmcp_cost_calc #(
    .CELL_BITS (CELL_BITS)
  ) u_cost_calc (
    .cell_value_i (s1_value_q),
    .pos_i        (s1_pos_q),
    .above_i      (above),
    .diag_i       (diag_q),
    .left_i       (left_q),
    .cost_o       (cost)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      diag_q <= '0;
    end else if (cfg_hit) begin
      left_q <= '0;
      diag_q <= '0;
    end else if (s1_go) begin
      if (s1_last_q) begin
        left_q <= '0;
        diag_q <= '0;
      end else begin
        left_q <= cost;
        diag_q <= above;
      end
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (cost_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_last_q) begin
      out_cost_q <= cost;
    end
  end

  assign cost_o.valid     = out_valid_q;
  assign cost_o.path_cost = out_cost_q;

  // ---------------------------------------------------------------- checks
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= cols_last) && (row_q <= rows_last))
    else $error("cell position beyond grid size");

  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted cell did not reach stage 1");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_last_q && s1_valid_q))
    else $error("result raised without a finishing cell");

  a_fwd_needs_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s1_valid_q |-> s1_go)
    else $error("cell accepted over a stalled stage 1");

endmodule : grid_min_cost_path

`default_nettype wire
